// ===== rtl/core/rpn_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants of the rpn stack calculator
package rpn_pkg;

	localparam int unsigned DATA_W  = 32;
	localparam int unsigned DEPTH_W = 7;
	localparam int unsigned DIV_STEPS = 32;

	typedef enum logic [2:0] {
		OP_PUSH = 3'd0,
		OP_ADD  = 3'd1,
		OP_SUB  = 3'd2,
		OP_MUL  = 3'd3,
		OP_DIV  = 3'd4,
		OP_PEEK = 3'd5,
		OP_SWAP = 3'd6,
		OP_POP  = 3'd7
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_UNDER = 2'd1,
		ST_FULL  = 2'd2,
		ST_DIVZ  = 2'd3
	} status_t;

	typedef struct packed {
		logic              start;
		logic [DATA_W-1:0] dividend;
		logic [DATA_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [DATA_W-1:0] quotient;
	} div_rsp_t;

endpackage

// ===== rtl/core/rpn_cmd_if.sv =====
`timescale 1ns / 1ps
// command channel of the rpn stack calculator
interface rpn_cmd_if;
	logic                              valid;
	logic                              ready;
	rpn_pkg::op_t                      op;
	logic signed [rpn_pkg::DATA_W-1:0] push_value;

	modport source (output valid, output op, output push_value, input ready);
	modport sink (input valid, input op, input push_value, output ready);
endinterface

// ===== rtl/core/rpn_res_if.sv =====
`timescale 1ns / 1ps
// result channel of the rpn stack calculator
interface rpn_res_if;
	logic                              valid;
	logic                              ready;
	logic signed [rpn_pkg::DATA_W-1:0] top_value;
	rpn_pkg::status_t                  status;
	logic [rpn_pkg::DEPTH_W-1:0]       stack_depth;

	modport source (output valid, output top_value, output status, output stack_depth,
		input ready);
	modport sink (input valid, input top_value, input status, input stack_depth,
		output ready);
endinterface

// ===== rtl/core/rpn_ram.sv =====
`timescale 1ns / 1ps
// generic simple dual-port ram with registered read
module rpn_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/core/rpn_div.sv =====
`timescale 1ns / 1ps
// radix-2 restoring signed divider, truncating toward zero
module rpn_div (
	input  logic              clk,
	input  logic              arst_n,
	input  rpn_pkg::div_req_t req,
	output rpn_pkg::div_rsp_t rsp
);
	localparam int unsigned W  = rpn_pkg::DATA_W;
	localparam int unsigned CW = $clog2(rpn_pkg::DIV_STEPS);

	logic          busy_q;
	logic          fix_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic          neg_q;
	logic [W-1:0]  dmag_q;
	logic [W-1:0]  rem_q;
	logic [W-1:0]  quo_q;
	logic [W-1:0]  res_q;

	logic [W:0]    shifted;
	logic [W:0]    diff;
	logic [W-1:0]  nmag;
	logic [W-1:0]  dmag;

	assign nmag    = req.dividend[W-1] ? (W'(0) - req.dividend) : req.dividend;
	assign dmag    = req.divisor[W-1] ? (W'(0) - req.divisor) : req.divisor;
	assign shifted = {rem_q, quo_q[W-1]};
	assign diff    = shifted - {1'b0, dmag_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fix_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			// done follows the single sign fixup cycle
			done_q <= fix_q;
			if (req.start && !busy_q && !fix_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				neg_q  <= req.dividend[W-1] ^ req.divisor[W-1];
				dmag_q <= dmag;
				rem_q  <= '0;
				quo_q  <= nmag;
			end else if (busy_q) begin
				// one quotient bit per cycle
				if (!diff[W]) begin
					rem_q <= diff[W-1:0];
					quo_q <= {quo_q[W-2:0], 1'b1};
				end else begin
					rem_q <= shifted[W-1:0];
					quo_q <= {quo_q[W-2:0], 1'b0};
				end
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(rpn_pkg::DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					fix_q  <= 1'b1;
				end
			end else if (fix_q) begin
				// sign fixup
				fix_q  <= 1'b0;
				res_q  <= neg_q ? (W'(0) - quo_q) : quo_q;
			end
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = res_q;
endmodule

// ===== rtl/core/rpn_stack_calculator_top.sv =====
`timescale 1ns / 1ps
// top level of the rpn stack calculator
//
// usage
//  - cmd carries one command per transaction (op, push_value); res returns
//    exactly one transaction per command (top_value, status, stack_depth)
//  - a transaction moves when valid and ready are both high at a clock edge
//  - commands run one at a time: push, peek, pop of a single item and the
//    short-stack errors go from check to the final state; a deeper pop
//    passes a load state, add/sub/mul and divide by zero an exec state, swap
//    exec and a second write, divide exec, 32 divider steps and sign fixup
//  - the stack lives in a ram with one write and one registered read port;
//    the top entry is also cached in a register so that only the second
//    operand needs a ram read
//  - cmd.ready is high whenever no command is in flight; a command may be
//    accepted while the previous result still sits in the output register
//  - if res is stalled, the finished command waits in its last state until
//    the output register frees up, and no new command is taken meanwhile
//  - reset empties the stack at once (stack pointer to zero); the ram is not
//    cleared, as no entry at or above the stack pointer is ever used
module rpn_stack_calculator_top #(
	parameter int unsigned STACK_DEPTH = 64
) (
	input logic        clk,
	input logic        arst_n,
	rpn_cmd_if.sink    cmd,
	rpn_res_if.source  res
);
	localparam int unsigned W  = rpn_pkg::DATA_W;
	localparam int unsigned AW = $clog2(STACK_DEPTH);
	localparam int unsigned PW = $clog2(STACK_DEPTH + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_LOAD,
		S_EXEC,
		S_SWAP2,
		S_DIVW,
		S_FIN
	} state_t;

	state_t            state_q;
	logic [PW-1:0]     sp_q;
	logic [W-1:0]      top_q;        // cached copy of the top entry
	logic [W-1:0]      b_q;          // second operand for the swap write-back
	logic [W-1:0]      pop_val_q;
	logic              pop_ok_q;
	rpn_pkg::op_t      op_q;
	logic [W-1:0]      push_q;
	rpn_pkg::status_t  stat_q;

	logic              out_valid_q;
	logic [W-1:0]      out_top_q;
	rpn_pkg::status_t  out_stat_q;
	logic [rpn_pkg::DEPTH_W-1:0] out_depth_q;

	// ram ports
	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [W-1:0]      mem_wdata;
	logic [AW-1:0]     mem_raddr;
	logic [W-1:0]      mem_rdata;

	logic [PW-1:0]     sp_m1;
	logic [PW-1:0]     sp_m2;
	logic              sp_full;
	logic              sp_empty;
	logic              sp_lt2;
	logic [W-1:0]      alu_res;
	logic              out_free;

	rpn_pkg::div_req_t div_req;
	rpn_pkg::div_rsp_t div_rsp;

	assign sp_m1    = sp_q - PW'(1);
	assign sp_m2    = sp_q - PW'(2);
	assign sp_full  = (sp_q == PW'(STACK_DEPTH));
	assign sp_empty = (sp_q == '0);
	assign sp_lt2   = (sp_q < PW'(2));
	assign out_free = !out_valid_q || res.ready;

	// second operand sits just below the top
	assign mem_raddr = sp_m2[AW-1:0];

	always_comb begin
		case (op_q)
			rpn_pkg::OP_ADD: alu_res = top_q + mem_rdata;
			rpn_pkg::OP_SUB: alu_res = top_q - mem_rdata;
			rpn_pkg::OP_MUL: alu_res = top_q * mem_rdata;
			default:         alu_res = top_q;
		endcase
	end

	// divider kicks off from the exec state with a = top, b = ram data
	assign div_req.start    = (state_q == S_EXEC) && (op_q == rpn_pkg::OP_DIV)
		&& (mem_rdata != '0);
	assign div_req.dividend = top_q;
	assign div_req.divisor  = mem_rdata;

	// write port selection
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = sp_q[AW-1:0];
		mem_wdata = push_q;
		case (state_q)
			S_CHECK: begin
				mem_we = (op_q == rpn_pkg::OP_PUSH) && !sp_full;
			end
			S_EXEC: begin
				mem_waddr = sp_m2[AW-1:0];
				if (op_q == rpn_pkg::OP_SWAP) begin
					mem_we    = 1'b1;
					mem_wdata = top_q;
				end else if (op_q == rpn_pkg::OP_ADD || op_q == rpn_pkg::OP_SUB
					|| op_q == rpn_pkg::OP_MUL) begin
					mem_we    = 1'b1;
					mem_wdata = alu_res;
				end
			end
			S_SWAP2: begin
				mem_we    = 1'b1;
				mem_waddr = sp_m1[AW-1:0];
				mem_wdata = b_q;
			end
			S_DIVW: begin
				mem_we    = div_rsp.done;
				mem_waddr = sp_m2[AW-1:0];
				mem_wdata = div_rsp.quotient;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	rpn_ram #(
		.WIDTH(W),
		.DEPTH(STACK_DEPTH)
	) u_stack_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	rpn_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// sequencer, stack pointer, top cache and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			sp_q        <= '0;
			pop_ok_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// in the final state the load below decides the output valid
			if (out_valid_q && res.ready && state_q != S_FIN) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd.valid) begin
						op_q     <= cmd.op;
						push_q   <= cmd.push_value;
						stat_q   <= rpn_pkg::ST_OK;
						pop_ok_q <= 1'b0;
						state_q  <= S_CHECK;
					end
				end
				S_CHECK: begin
					// ram read of the entry below the top is in flight
					case (op_q)
						rpn_pkg::OP_PUSH: begin
							state_q <= S_FIN;
							if (sp_full) begin
								stat_q <= rpn_pkg::ST_FULL;
							end else begin
								top_q <= push_q;
								sp_q  <= sp_q + PW'(1);
							end
						end
						rpn_pkg::OP_PEEK: begin
							state_q <= S_FIN;
							if (sp_empty) begin
								stat_q <= rpn_pkg::ST_UNDER;
							end
						end
						rpn_pkg::OP_POP: begin
							if (sp_empty) begin
								stat_q  <= rpn_pkg::ST_UNDER;
								state_q <= S_FIN;
							end else begin
								pop_ok_q  <= 1'b1;
								pop_val_q <= top_q;
								if (sp_lt2) begin
									sp_q    <= sp_m1;
									state_q <= S_FIN;
								end else begin
									state_q <= S_LOAD;
								end
							end
						end
						default: begin
							if (sp_lt2) begin
								stat_q  <= rpn_pkg::ST_UNDER;
								state_q <= S_FIN;
							end else begin
								state_q <= S_EXEC;
							end
						end
					endcase
				end
				S_LOAD: begin
					// refill the top cache after a pop
					top_q   <= mem_rdata;
					sp_q    <= sp_m1;
					state_q <= S_FIN;
				end
				S_EXEC: begin
					b_q <= mem_rdata;
					if (op_q == rpn_pkg::OP_SWAP) begin
						top_q   <= mem_rdata;
						state_q <= S_SWAP2;
					end else if (op_q == rpn_pkg::OP_DIV) begin
						if (mem_rdata == '0) begin
							stat_q  <= rpn_pkg::ST_DIVZ;
							state_q <= S_FIN;
						end else begin
							state_q <= S_DIVW;
						end
					end else begin
						top_q   <= alu_res;
						sp_q    <= sp_m1;
						state_q <= S_FIN;
					end
				end
				S_SWAP2: begin
					state_q <= S_FIN;
				end
				S_DIVW: begin
					if (div_rsp.done) begin
						top_q   <= div_rsp.quotient;
						sp_q    <= sp_m1;
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					// hold here while the previous result is still unclaimed
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_stat_q  <= stat_q;
						out_depth_q <= rpn_pkg::DEPTH_W'(sp_q);
						if (pop_ok_q) begin
							out_top_q <= pop_val_q;
						end else if (sp_empty) begin
							out_top_q <= '0;
						end else begin
							out_top_q <= top_q;
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign cmd.ready       = (state_q == S_IDLE);
	assign res.valid       = out_valid_q;
	assign res.top_value   = out_top_q;
	assign res.status      = out_stat_q;
	assign res.stack_depth = out_depth_q;

	// stack pointer stays within the stack
	a_sp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= PW'(STACK_DEPTH))
		else $error("stack pointer beyond stack depth");

	// stack pointer moves by at most one per cycle
	a_sp_step: assert property (@(posedge clk) disable iff (!arst_n)
		(sp_q == $past(sp_q)) || (sp_q == $past(sp_q) + PW'(1))
		|| (sp_q == $past(sp_q) - PW'(1)))
		else $error("stack pointer jumped");

	// divider result only arrives while waiting for it
	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == S_DIVW))
		else $error("divider result outside wait state");

	// a result is loaded only when the output register is free
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN) && out_valid_q && !res.ready |=> out_valid_q
		&& (state_q == S_FIN))
		else $error("result overwritten while stalled");
endmodule
